// File: hdl/c_subset_lexer_defines.svh
// assertion macros for the c subset lexer
// used by the top level; no other dependencies

`ifndef C_SUBSET_LEXER_DEFINES_SVH
`define C_SUBSET_LEXER_DEFINES_SVH

`ifndef ASSERT_OFF

// condition must never hold outside reset
`define CSL_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("check failed: never");

// same-cycle implication
`define CSL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed: implication");

// next-cycle implication
`define CSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed: next cycle");

`else

`define CSL_ASSERT_NEVER(lbl, clk, rstn, cond)
`define CSL_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define CSL_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: hdl/csl_pkg.sv
// shared types, constants and character helpers for the c subset lexer
// no dependencies

`default_nettype none

package csl_pkg;

    localparam int MAX_TOKEN     = 1024;
    localparam int POSITION_BITS = 20;
    localparam int WL_W          = $clog2(MAX_TOKEN + 1);
    localparam int LEN_W         = 11;
    localparam int START_W       = 20;
    localparam int BYTE_W        = 8;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [3:0] {
        KIND_NAME    = 4'd0,
        KIND_NUMBER  = 4'd1,
        KIND_INT     = 4'd2,
        KIND_RETURN  = 4'd3,
        KIND_LPAREN  = 4'd4,
        KIND_RPAREN  = 4'd5,
        KIND_COMMA   = 4'd6,
        KIND_LBRACE  = 4'd7,
        KIND_RBRACE  = 4'd8,
        KIND_PLUS    = 4'd9,
        KIND_SEMI    = 4'd10,
        KIND_STAR    = 4'd11,
        KIND_MINUS   = 4'd12,
        KIND_SLASH   = 4'd13,
        KIND_ASSIGN  = 4'd14
    } kind_t;

    typedef struct packed {
        logic                 token_valid;
        kind_t                token_kind;
        logic [LEN_W-1:0]     token_length;
        logic [START_W-1:0]   token_start;
        logic                 binary_operator;
        logic                 scan_truncated;
        logic                 last_result;
    } result_t;

    // results produced by one accepted byte
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == 8'h20) || (c == 8'h0a) || (c == 8'h09);
    endfunction

    function automatic logic is_numeral(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_special(input logic [BYTE_W-1:0] c);
        logic hit;
        unique case (c)
            8'h28, 8'h29, 8'h2c, 8'h7b, 8'h7d, 8'h2b,
            8'h3b, 8'h2a, 8'h2d, 8'h2f, 8'h3d: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic kind_t special_kind(input logic [BYTE_W-1:0] c);
        kind_t k;
        unique case (c)
            8'h28:   k = KIND_LPAREN;   // (
            8'h29:   k = KIND_RPAREN;   // )
            8'h2c:   k = KIND_COMMA;    // ,
            8'h7b:   k = KIND_LBRACE;   // {
            8'h7d:   k = KIND_RBRACE;   // }
            8'h2b:   k = KIND_PLUS;     // +
            8'h3b:   k = KIND_SEMI;     // ;
            8'h2a:   k = KIND_STAR;     // *
            8'h2d:   k = KIND_MINUS;    // -
            8'h2f:   k = KIND_SLASH;    // /
            8'h3d:   k = KIND_ASSIGN;   // =
            default: k = KIND_NAME;
        endcase
        return k;
    endfunction

    // expected character of keyword int at a match position
    function automatic logic [BYTE_W-1:0] int_char(input logic [1:0] idx);
        logic [BYTE_W-1:0] ch;
        unique case (idx)
            2'd0:    ch = 8'h69;    // i
            2'd1:    ch = 8'h6e;    // n
            2'd2:    ch = 8'h74;    // t
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // expected character of keyword return at a match position
    function automatic logic [BYTE_W-1:0] ret_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] ch;
        unique case (idx)
            3'd0:    ch = 8'h72;    // r
            3'd1:    ch = 8'h65;    // e
            3'd2:    ch = 8'h74;    // t
            3'd3:    ch = 8'h75;    // u
            3'd4:    ch = 8'h72;    // r
            3'd5:    ch = 8'h6e;    // n
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_binop(input kind_t k);
        return (k == KIND_PLUS) || (k == KIND_STAR) || (k == KIND_MINUS)
            || (k == KIND_SLASH);
    endfunction

    // token for a finished word
    function automatic result_t make_word(
        input logic [WL_W-1:0]          len,
        input logic [1:0]               mismatch,
        input logic                     all_digits,
        input logic [POSITION_BITS-1:0] start,
        input logic                     trunc
    );
        result_t r;
        r = '0;
        r.token_valid = 1'b1;
        priority if (len == WL_W'(3) && !mismatch[0])
            r.token_kind = KIND_INT;
        else if (len == WL_W'(6) && !mismatch[1])
            r.token_kind = KIND_RETURN;
        else if (all_digits)
            r.token_kind = KIND_NUMBER;
        else
            r.token_kind = KIND_NAME;
        r.token_length    = LEN_W'(len);
        r.token_start     = START_W'(start);
        r.binary_operator = 1'b0;
        r.scan_truncated  = trunc;
        return r;
    endfunction

    // token for a one-character punctuator
    function automatic result_t make_special(
        input kind_t                    k,
        input logic [POSITION_BITS-1:0] start
    );
        result_t r;
        r = '0;
        r.token_valid     = 1'b1;
        r.token_kind      = k;
        r.token_length    = LEN_W'(1);
        r.token_start     = START_W'(start);
        r.binary_operator = is_binop(k);
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/csl_in_if.sv
// input byte channel of the c subset lexer
// depends on csl_pkg

`default_nettype none

interface csl_in_if;
    logic                       valid;
    logic                       ready;
    logic [csl_pkg::BYTE_W-1:0] in_byte;
    logic                       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// File: hdl/csl_out_if.sv
// token result channel of the c subset lexer
// depends on csl_pkg

`default_nettype none

interface csl_out_if;
    logic                        valid;
    logic                        ready;
    logic                        token_valid;
    logic [3:0]                  token_kind;
    logic [csl_pkg::LEN_W-1:0]   token_length;
    logic [csl_pkg::START_W-1:0] token_start;
    logic                        binary_operator;
    logic                        scan_truncated;
    logic                        last_result;

    modport source (
        output valid, output token_valid, output token_kind, output token_length,
        output token_start, output binary_operator, output scan_truncated,
        output last_result, input ready
    );
    modport sink (
        input valid, input token_valid, input token_kind, input token_length,
        input token_start, input binary_operator, input scan_truncated,
        input last_result, output ready
    );
endinterface

`default_nettype wire

// File: hdl/csl_scan.sv
// scanner state and per-byte token logic of the c subset lexer
// depends on csl_pkg

`default_nettype none

module csl_scan (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [csl_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                       end_of_input,
    output csl_pkg::push_t                  push
);

    logic [csl_pkg::WL_W-1:0]          wl_reg, wl_next;
    logic [csl_pkg::POSITION_BITS-1:0] start_reg, start_next;
    logic [csl_pkg::POSITION_BITS-1:0] pos_reg, pos_next;
    logic                              digits_reg, digits_next;
    logic [1:0]                        int_prog_reg, int_prog_next;
    logic [2:0]                        ret_prog_reg, ret_prog_next;
    logic [1:0]                        mism_reg, mism_next;
    logic                              stopped_reg, stopped_next;

    // word state after appending the current byte
    logic [csl_pkg::WL_W-1:0]          app_wl;
    logic [csl_pkg::POSITION_BITS-1:0] app_start;
    logic                              app_digits;
    logic [1:0]                        app_int_prog;
    logic [2:0]                        app_ret_prog;
    logic [1:0]                        app_mism;

    logic byte_is_zero;
    logic byte_is_space;
    logic byte_is_special;
    logic word_pending;
    logic at_limit;

    assign byte_is_zero    = (in_byte == '0);
    assign byte_is_space   = csl_pkg::is_space(in_byte);
    assign byte_is_special = csl_pkg::is_special(in_byte);
    assign word_pending    = (wl_reg != '0);
    assign at_limit        = (wl_reg >= csl_pkg::WL_W'(csl_pkg::MAX_TOKEN));

    // append: start offset, keyword matching and digit tracking
    always_comb
    begin
        app_wl       = wl_reg + csl_pkg::WL_W'(1);
        app_start    = word_pending ? start_reg : pos_reg;
        app_digits   = digits_reg & csl_pkg::is_numeral(in_byte);
        app_int_prog = int_prog_reg;
        app_ret_prog = ret_prog_reg;
        app_mism     = mism_reg;
        if (!mism_reg[0])
        begin
            if (wl_reg < csl_pkg::WL_W'(3) && int_prog_reg < 2'd3
                && in_byte == csl_pkg::int_char(int_prog_reg))
                app_int_prog = int_prog_reg + 2'd1;
            else
                app_mism[0] = 1'b1;
        end
        if (!mism_reg[1])
        begin
            if (wl_reg < csl_pkg::WL_W'(6) && ret_prog_reg < 3'd6
                && in_byte == csl_pkg::ret_char(ret_prog_reg))
                app_ret_prog = ret_prog_reg + 3'd1;
            else
                app_mism[1] = 1'b1;
        end
    end

    // next state and results for one accepted byte
    always_comb
    begin
        csl_pkg::result_t cur_word;
        cur_word = csl_pkg::make_word(wl_reg, mism_reg, digits_reg, start_reg, 1'b0);

        wl_next       = wl_reg;
        start_next    = start_reg;
        pos_next      = pos_reg;
        digits_next   = digits_reg;
        int_prog_next = int_prog_reg;
        ret_prog_next = ret_prog_reg;
        mism_next     = mism_reg;
        stopped_next  = stopped_reg;
        push          = '0;

        if (accept)
        begin
            priority if (stopped_reg)
            begin
                // discard until the text ends, then re-arm
                if (byte_is_zero || end_of_input)
                begin
                    wl_next = '0; start_next = '0; digits_next = 1'b1;
                    int_prog_next = '0; ret_prog_next = '0; mism_next = '0;
                    pos_next = '0; stopped_next = 1'b0;
                end
            end
            else if (byte_is_zero)
            begin
                // end of text: flush word or give bare marker
                push.count = 2'd1;
                if (word_pending)
                    push.res0 = cur_word;
                push.res0.last_result = 1'b1;
                wl_next = '0; start_next = '0; digits_next = 1'b1;
                int_prog_next = '0; ret_prog_next = '0; mism_next = '0;
                pos_next = '0; stopped_next = 1'b0;
            end
            else if (at_limit)
            begin
                // length limit: give word as truncated, stop unless text ends
                push.count = 2'd1;
                push.res0 = csl_pkg::make_word(wl_reg, mism_reg, digits_reg,
                                               start_reg, 1'b1);
                push.res0.last_result = 1'b1;
                wl_next = '0; start_next = '0; digits_next = 1'b1;
                int_prog_next = '0; ret_prog_next = '0; mism_next = '0;
                pos_next = '0; stopped_next = !end_of_input;
            end
            else
            begin
                pos_next = pos_reg + csl_pkg::POSITION_BITS'(1);
                if (byte_is_space || byte_is_special)
                begin
                    if (byte_is_special)
                    begin
                        if (word_pending)
                        begin
                            push.count = 2'd2;
                            push.res0  = cur_word;
                            push.res1  = csl_pkg::make_special(
                                csl_pkg::special_kind(in_byte), pos_reg);
                        end
                        else
                        begin
                            push.count = 2'd1;
                            push.res0  = csl_pkg::make_special(
                                csl_pkg::special_kind(in_byte), pos_reg);
                        end
                    end
                    else if (word_pending)
                    begin
                        push.count = 2'd1;
                        push.res0  = cur_word;
                    end
                    wl_next = '0; start_next = '0; digits_next = 1'b1;
                    int_prog_next = '0; ret_prog_next = '0; mism_next = '0;
                end
                else
                begin
                    wl_next       = app_wl;
                    start_next    = app_start;
                    digits_next   = app_digits;
                    int_prog_next = app_int_prog;
                    ret_prog_next = app_ret_prog;
                    mism_next     = app_mism;
                end

                // end of text on this byte
                if (end_of_input)
                begin
                    if (!byte_is_space && !byte_is_special)
                    begin
                        push.count = 2'd1;
                        push.res0  = csl_pkg::make_word(app_wl, app_mism, app_digits,
                                                        app_start, 1'b0);
                    end
                    else if (push.count == 2'd0)
                    begin
                        push.count = 2'd1;
                        push.res0  = '0;
                    end
                    if (push.count == 2'd2)
                        push.res1.last_result = 1'b1;
                    else
                        push.res0.last_result = 1'b1;
                    wl_next = '0; start_next = '0; digits_next = 1'b1;
                    int_prog_next = '0; ret_prog_next = '0; mism_next = '0;
                    pos_next = '0; stopped_next = 1'b0;
                end
            end
        end
    end

    // scanner state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg       <= '0;
            start_reg    <= '0;
            pos_reg      <= '0;
            digits_reg   <= 1'b1;
            int_prog_reg <= '0;
            ret_prog_reg <= '0;
            mism_reg     <= '0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            wl_reg       <= wl_next;
            start_reg    <= start_next;
            pos_reg      <= pos_next;
            digits_reg   <= digits_next;
            int_prog_reg <= int_prog_next;
            ret_prog_reg <= ret_prog_next;
            mism_reg     <= mism_next;
            stopped_reg  <= stopped_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/c_subset_lexer.sv
// top level of the c subset lexer: scanner plus result queue
// depends on csl_pkg, csl_in_if, csl_out_if, csl_scan, c_subset_lexer_defines.svh
//
// channel   dir  payload
// in_ch     in   in_byte[7:0], end_of_input
// out_ch    out  token_valid, token_kind[3:0], token_length[10:0], token_start[19:0],
//                binary_operator, scan_truncated, last_result
//
// one byte is accepted per cycle while the result queue has two free entries
// results appear in the cycle after the byte, leave one per ready cycle; a byte that
// ends a word on a punctuator gives two results, so the output port sets the pace
// reset clears scanner state and queue pointers; queue contents are not reset
// a stall on out_ch holds off in_ch once three of the four queue entries are in use

`default_nettype none

`include "c_subset_lexer_defines.svh"

module c_subset_lexer (
    input wire logic  clk,
    input wire logic  rst_n,
    csl_in_if.sink    in_ch,
    csl_out_if.source out_ch
);

    logic                      in_xfer;
    logic                      out_xfer;
    csl_pkg::push_t            push;
    csl_pkg::result_t          head;

    csl_pkg::result_t          fifo_mem_reg [csl_pkg::FIFO_DEPTH];
    logic [csl_pkg::FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [csl_pkg::FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [csl_pkg::FIFO_CW-1:0] count_reg, count_next;

    // room for the worst case of two results per byte
    assign in_ch.ready = (count_reg <= csl_pkg::FIFO_CW'(csl_pkg::FIFO_DEPTH - 2));
    assign in_xfer     = in_ch.valid && in_ch.ready;
    assign out_xfer    = out_ch.valid && out_ch.ready;

    csl_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_xfer),
        .in_byte      (in_ch.in_byte),
        .end_of_input (in_ch.end_of_input),
        .push         (push)
    );

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + csl_pkg::FIFO_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + csl_pkg::FIFO_AW'(out_xfer);
        count_next  = count_reg + csl_pkg::FIFO_CW'(push.count)
                    - csl_pkg::FIFO_CW'(out_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage, up to two writes per cycle
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            fifo_mem_reg[wr_ptr_reg] <= push.res0;
        if (push.count == 2'd2)
            fifo_mem_reg[wr_ptr_reg + csl_pkg::FIFO_AW'(1)] <= push.res1;
    end

    // output side
    assign head                   = fifo_mem_reg[rd_ptr_reg];
    assign out_ch.valid           = (count_reg != '0);
    assign out_ch.token_valid     = head.token_valid;
    assign out_ch.token_kind      = 4'(head.token_kind);
    assign out_ch.token_length    = head.token_length;
    assign out_ch.token_start     = head.token_start;
    assign out_ch.binary_operator = head.binary_operator;
    assign out_ch.scan_truncated  = head.scan_truncated;
    assign out_ch.last_result     = head.last_result;

    // checks
    `CSL_ASSERT_NEVER(a_no_overflow, clk, rst_n, count_reg > csl_pkg::FIFO_CW'(csl_pkg::FIFO_DEPTH))
    `CSL_ASSERT_NEXT(a_push_shows, clk, rst_n, push.count != 2'd0, out_ch.valid)
    `CSL_ASSERT_NEXT(a_stall_keeps, clk, rst_n, !out_xfer, count_reg >= $past(count_reg))
    `CSL_ASSERT_IMPL(a_last_on_second, clk, rst_n, push.count == 2'd2, !push.res0.last_result)

endmodule

`default_nettype wire
